### design/light_driven_servo_ramp_controller_assert.svh
// Assertion macros for the light-driven servo ramp controller.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef LIGHT_DRIVEN_SERVO_RAMP_CONTROLLER_ASSERT_SVH
`define LIGHT_DRIVEN_SERVO_RAMP_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent holds in the same cycle as the antecedent.
`define LSRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LSRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LSRC_ASSERT_SAME(label, ante, cons, msg)
`define LSRC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### design/lsrc_pkg.sv
package lsrc_pkg;

    // Event kinds.
    localparam logic [1:0] FUNC_LIGHT = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_CMD   = 2'd2;

    // Panel modes.
    localparam logic [1:0] MODE_CLOSED  = 2'd0;
    localparam logic [1:0] MODE_CLOSING = 2'd1;
    localparam logic [1:0] MODE_OPEN    = 2'd2;
    localparam logic [1:0] MODE_OPENING = 2'd3;

    // Status byte codes.
    localparam logic [1:0] STATUS_DARK   = 2'd0;
    localparam logic [1:0] STATUS_BRIGHT = 2'd1;
    localparam logic [1:0] STATUS_OPEN   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_LIGHT_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_CLOSED_DUTY     = 2'd1;
    localparam logic [1:0] REG_OPEN_DUTY       = 2'd2;
    localparam logic [1:0] REG_TICKS_PER_STEP  = 2'd3;

    // Reset values.
    localparam logic [7:0] RST_LIGHT_THRESHOLD = 8'd15;
    localparam logic [7:0] RST_CLOSED_DUTY     = 8'd15;
    localparam logic [7:0] RST_OPEN_DUTY       = 8'd28;
    localparam logic [7:0] RST_TICKS_PER_STEP  = 8'd15;

    // The command value that requests the panel to open.
    localparam logic [7:0] CMD_OPEN = 8'd1;

endpackage

### design/light_driven_servo_ramp_controller.sv
// Light-driven servo ramp controller.
// Input channel (in_valid/in_ready, func, value) carries events: a light sample,
// a 10 ms tick or a command byte. Every event produces exactly one result on the
// output channel (out_valid/out_ready, status_byte, duty_out, panel_mode,
// indicator), which reports the state after that event.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata; it should be
// changed only while no event is in flight.
// A result is registered and appears in the cycle after its event transfer. The
// block takes one event per cycle while the receiver keeps taking results: the
// state update and the result are computed by one level of logic from the current
// state and the event, and the result register refills in the same cycle it is emptied.
// When the receiver stalls, the held result stays put and in_ready drops until
// the result is transferred; no event is lost or repeated.
// Reset clears the panel to closed with duty 15, dark phase, no pending command,
// and loads the default configuration; the output channel comes up empty.
module light_driven_servo_ramp_controller (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status_byte,
    output logic [7:0] duty_out,
    output logic [1:0] panel_mode,
    output logic       indicator,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata
);

`include "light_driven_servo_ramp_controller_assert.svh"

    // Configuration registers.
    logic [7:0] light_threshold_reg;
    logic [7:0] closed_duty_reg;
    logic [7:0] open_duty_reg;
    logic [7:0] ticks_per_step_reg;

    // Controller state.
    logic [7:0] light_level_reg, light_level_next;
    logic       bright_phase_reg, bright_phase_next;
    logic [7:0] pending_cmd_reg, pending_cmd_next;
    logic [1:0] mode_reg, mode_next;
    logic [7:0] duty_reg, duty_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [1:0] status_reg, status_next;
    logic       indicator_reg, indicator_next;

    // Result register.
    logic       out_valid_reg;
    logic [1:0] res_status_reg;
    logic [7:0] res_duty_reg;
    logic [1:0] res_mode_reg;
    logic       res_indicator_reg;

    logic       in_xfer;
    logic       ramping;
    logic       opening;
    logic [7:0] target;
    logic [7:0] tick_inc;
    logic       bright;

    // The result register accepts a new event whenever it is empty or being drained.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_threshold_reg <= lsrc_pkg::RST_LIGHT_THRESHOLD;
            closed_duty_reg     <= lsrc_pkg::RST_CLOSED_DUTY;
            open_duty_reg       <= lsrc_pkg::RST_OPEN_DUTY;
            ticks_per_step_reg  <= lsrc_pkg::RST_TICKS_PER_STEP;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lsrc_pkg::REG_LIGHT_THRESHOLD: light_threshold_reg <= cfg_wdata;
                lsrc_pkg::REG_CLOSED_DUTY:     closed_duty_reg     <= cfg_wdata;
                lsrc_pkg::REG_OPEN_DUTY:       open_duty_reg       <= cfg_wdata;
                lsrc_pkg::REG_TICKS_PER_STEP:  ticks_per_step_reg  <= cfg_wdata;
                default:                       ;
            endcase
        end
    end

    // Ramp helpers derived from the current mode.
    assign ramping  = (mode_reg == lsrc_pkg::MODE_OPENING) ||
                      (mode_reg == lsrc_pkg::MODE_CLOSING);
    assign opening  = (mode_reg == lsrc_pkg::MODE_OPENING);
    assign target   = opening ? open_duty_reg : closed_duty_reg;
    assign tick_inc = tick_count_reg + 8'd1;

    // Next state for one event: apply the event, update the phase, then run the
    // phase action.
    always_comb
    begin
        light_level_next  = light_level_reg;
        bright_phase_next = bright_phase_reg;
        pending_cmd_next  = pending_cmd_reg;
        mode_next         = mode_reg;
        duty_next         = duty_reg;
        tick_count_next   = tick_count_reg;
        status_next       = status_reg;
        indicator_next    = indicator_reg;

        case (func)
            lsrc_pkg::FUNC_LIGHT:
            begin
                light_level_next = value;
            end
            lsrc_pkg::FUNC_TICK:
            begin
                if (ramping)
                begin
                    tick_count_next = tick_inc;
                    if (duty_reg == target)
                    begin
                        // The limit is reached: the ramp ends without a step.
                        mode_next       = opening ? lsrc_pkg::MODE_OPEN : lsrc_pkg::MODE_CLOSED;
                        status_next     = opening ? lsrc_pkg::STATUS_OPEN
                                                  : lsrc_pkg::STATUS_DARK;
                        tick_count_next = 8'd0;
                    end
                    else if (tick_inc == ticks_per_step_reg)
                    begin
                        duty_next       = opening ? duty_reg + 8'd1 : duty_reg - 8'd1;
                        tick_count_next = 8'd0;
                    end
                end
            end
            lsrc_pkg::FUNC_CMD:
            begin
                pending_cmd_next = value;
                indicator_next   = 1'b1;
            end
            default:
            begin
            end
        endcase

        // A change of phase reloads the status.
        bright = (light_level_next > light_threshold_reg);
        if (bright != bright_phase_reg)
        begin
            bright_phase_next = bright;
            status_next       = bright ? lsrc_pkg::STATUS_BRIGHT : lsrc_pkg::STATUS_DARK;
        end

        // Bright phase opens a closed panel on command; dark phase closes an open one.
        if (bright_phase_next)
        begin
            if (pending_cmd_next == lsrc_pkg::CMD_OPEN &&
                mode_next == lsrc_pkg::MODE_CLOSED)
            begin
                mode_next        = lsrc_pkg::MODE_OPENING;
                pending_cmd_next = 8'd0;
                indicator_next   = 1'b1;
            end
        end
        else if (mode_next == lsrc_pkg::MODE_OPEN)
        begin
            mode_next      = lsrc_pkg::MODE_CLOSING;
            indicator_next = 1'b0;
        end
    end

    // State update on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_level_reg  <= 8'd0;
            bright_phase_reg <= 1'b0;
            pending_cmd_reg  <= 8'd0;
            mode_reg         <= lsrc_pkg::MODE_CLOSED;
            duty_reg         <= lsrc_pkg::RST_CLOSED_DUTY;
            tick_count_reg   <= 8'd0;
            status_reg       <= lsrc_pkg::STATUS_DARK;
            indicator_reg    <= 1'b0;
        end
        else if (in_xfer)
        begin
            light_level_reg  <= light_level_next;
            bright_phase_reg <= bright_phase_next;
            pending_cmd_reg  <= pending_cmd_next;
            mode_reg         <= mode_next;
            duty_reg         <= duty_next;
            tick_count_reg   <= tick_count_next;
            status_reg       <= status_next;
            indicator_reg    <= indicator_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with the post-event state.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_status_reg    <= status_next;
            res_duty_reg      <= duty_next;
            res_mode_reg      <= mode_next;
            res_indicator_reg <= indicator_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status_byte = res_status_reg;
    assign duty_out    = res_duty_reg;
    assign panel_mode  = res_mode_reg;
    assign indicator   = res_indicator_reg;

    // Every input transfer leaves a result waiting in the next cycle.
    `LSRC_ASSERT_NEXT(a_result_follows, in_xfer, out_valid_reg, "result missing after transfer")

    // A held result blocks new input so it cannot be overwritten.
    `LSRC_ASSERT_SAME(a_stall_blocks, out_valid_reg && !out_ready, !in_ready, "input accepted over a held result")

    // The duty only moves while a ramp is in progress.
    `LSRC_ASSERT_NEXT(a_duty_still, !ramping, duty_reg == $past(duty_reg), "duty changed outside a ramp")

    // The tick counter rests at zero whenever the panel is not ramping.
    `LSRC_ASSERT_SAME(a_tick_idle, !ramping, tick_count_reg == 8'd0, "tick count nonzero outside a ramp")

endmodule

### test/ramp_checker.sv
module ramp_checker
    import lsrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] value,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] status_byte,
    input  logic [7:0] duty_out,
    input  logic [1:0] panel_mode,
    input  logic       indicator,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    output int         mismatches,
    output int         awaited,
    output int         results_checked,
    output int         duty_steps,
    output int         ramps_done
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] duty;
        logic [1:0] mode;
        logic       ind;
    } panel_report_t;

    // Local copy of the configuration registers.
    logic [7:0] threshold;
    logic [7:0] closed_limit;
    logic [7:0] open_limit;
    logic [7:0] step_ticks;

    // Local copy of the panel state.
    logic [7:0] light_seen;
    logic       is_bright;
    logic [7:0] cmd_held;
    logic [1:0] mode_now;
    logic [7:0] duty_now;
    logic [7:0] tick_cnt;
    logic [1:0] status_now;
    logic       ind_now;

    panel_report_t report_q[$];

    // Applies one event to the local state and returns the report the block owes for it.
    function automatic panel_report_t apply_event(input logic [1:0] kind,
                                                  input logic [7:0] data);
        logic          opening;
        logic [7:0]    target;
        logic          bright;
        panel_report_t rep;

        case (kind)
            FUNC_LIGHT: light_seen = data;
            FUNC_CMD:
            begin
                cmd_held = data;
                ind_now  = 1'b1;
            end
            FUNC_TICK:
            begin
                if (mode_now == MODE_OPENING || mode_now == MODE_CLOSING)
                begin
                    opening  = (mode_now == MODE_OPENING);
                    target   = opening ? open_limit : closed_limit;
                    tick_cnt = tick_cnt + 8'd1;
                    if (duty_now == target)
                    begin
                        // The ramp has arrived; no step on this tick.
                        mode_now   = opening ? MODE_OPEN : MODE_CLOSED;
                        status_now = opening ? STATUS_OPEN : STATUS_DARK;
                        tick_cnt   = 8'd0;
                        ramps_done++;
                    end
                    else if (tick_cnt == step_ticks)
                    begin
                        duty_now = opening ? duty_now + 8'd1 : duty_now - 8'd1;
                        tick_cnt = 8'd0;
                        duty_steps++;
                    end
                end
            end
            default: ;
        endcase

        // Phase tracking; the status follows only a change of phase.
        bright = (light_seen > threshold);
        if (bright != is_bright)
        begin
            is_bright  = bright;
            status_now = bright ? STATUS_BRIGHT : STATUS_DARK;
        end

        // Phase action: open on request while bright, close when dark.
        if (is_bright)
        begin
            if (cmd_held == CMD_OPEN && mode_now == MODE_CLOSED)
            begin
                mode_now = MODE_OPENING;
                cmd_held = 8'd0;
                ind_now  = 1'b1;
            end
        end
        else if (mode_now == MODE_OPEN)
        begin
            mode_now = MODE_CLOSING;
            ind_now  = 1'b0;
        end

        rep.status = status_now;
        rep.duty   = duty_now;
        rep.mode   = mode_now;
        rep.ind    = ind_now;
        return rep;
    endfunction

    // Watch both channels and the register port on every rising edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        panel_report_t want;

        if (!rst_n)
        begin
            threshold       = RST_LIGHT_THRESHOLD;
            closed_limit    = RST_CLOSED_DUTY;
            open_limit      = RST_OPEN_DUTY;
            step_ticks      = RST_TICKS_PER_STEP;
            light_seen      = 8'd0;
            is_bright       = 1'b0;
            cmd_held        = 8'd0;
            mode_now        = MODE_CLOSED;
            duty_now        = RST_CLOSED_DUTY;
            tick_cnt        = 8'd0;
            status_now      = STATUS_DARK;
            ind_now         = 1'b0;
            mismatches      = 0;
            results_checked = 0;
            duty_steps      = 0;
            ramps_done      = 0;
            report_q.delete();
        end
        else
        begin
            // Result transfer: compare with the oldest expectation.
            if (out_valid && out_ready)
            begin
                if (report_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing expected: status %0d duty %0d mode %0d ind %0d",
                                 $time, status_byte, duty_out, panel_mode, indicator);
                    mismatches++;
                end
                else
                begin
                    want = report_q.pop_front();
                    results_checked++;
                    if (status_byte !== want.status || duty_out !== want.duty ||
                        panel_mode !== want.mode || indicator !== want.ind)
                    begin
                        if (mismatches < 10)
                            $display("%0t: mismatch: expected status %0d duty %0d mode %0d ind %0d, got status %0d duty %0d mode %0d ind %0d",
                                     $time, want.status, want.duty, want.mode, want.ind,
                                     status_byte, duty_out, panel_mode, indicator);
                        mismatches++;
                    end
                end
            end

            // Event transfer: predict its report.
            if (in_valid && in_ready)
                report_q.push_back(apply_event(func, value));

            // Register writes take effect for the following events.
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_LIGHT_THRESHOLD: threshold    = cfg_wdata;
                    REG_CLOSED_DUTY:     closed_limit = cfg_wdata;
                    REG_OPEN_DUTY:       open_limit   = cfg_wdata;
                    REG_TICKS_PER_STEP:  step_ticks   = cfg_wdata;
                    default: ;
                endcase
            end
        end
        awaited = report_q.size();
    end

endmodule

### test/tb.sv
module tb;
    import lsrc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Event kind that the block does not define.
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int         NUM_SETTINGS = 6;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [1:0] func      = FUNC_LIGHT;
    logic [7:0] value     = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] status_byte;
    logic [7:0] duty_out;
    logic [1:0] panel_mode;
    logic       indicator;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = REG_LIGHT_THRESHOLD;
    logic [7:0] cfg_wdata = 8'd0;

    int mismatches;
    int awaited;
    int results_checked;
    int duty_steps;
    int ramps_done;

    int         send_idle_pct = 35;
    int         recv_idle_pct = 59;
    int         events_sent   = 0;
    logic [7:0] cur_threshold = RST_LIGHT_THRESHOLD;

    // Register settings, one per phase: threshold, closed and open limits, ticks per step.
    logic [7:0] thr_tab    [NUM_SETTINGS] = '{8'd15, 8'd0,   8'd255, 8'd128, 8'd100, 8'd200};
    logic [7:0] closed_tab [NUM_SETTINGS] = '{8'd15, 8'd0,   8'd250, 8'd10,  8'd40,  8'd44};
    logic [7:0] open_tab   [NUM_SETTINGS] = '{8'd28, 8'd255, 8'd20,  8'd13,  8'd44,  8'd40};
    logic [7:0] tps_tab    [NUM_SETTINGS] = '{8'd2,  8'd255, 8'd1,   8'd0,   8'd3,   8'd1};
    int         items_tab  [NUM_SETTINGS] = '{45, 45, 45, 320, 45, 45};
    int         tick_tab   [NUM_SETTINGS] = '{50, 40, 50, 90, 55, 55};

    light_driven_servo_ramp_controller i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status_byte (status_byte),
        .duty_out    (duty_out),
        .panel_mode  (panel_mode),
        .indicator   (indicator),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    ramp_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .value           (value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status_byte     (status_byte),
        .duty_out        (duty_out),
        .panel_mode      (panel_mode),
        .indicator       (indicator),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .awaited         (awaited),
        .results_checked (results_checked),
        .duty_steps      (duty_steps),
        .ramps_done      (ramps_done)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random on the falling edge.
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Presents one event and holds it until the transfer happens.
    task automatic send_event(input logic [1:0] kind, input logic [7:0] data);
        // Each cycle the sender idles with the current idle percentage.
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        func     = kind;
        value    = data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        events_sent++;
    endtask

    // Stops sending and waits until every expected result has been transferred.
    task automatic drain_results();
        in_valid = 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_index = idx;
        cfg_wdata = data;
        cfg_wr_en = 1'b1;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (idx == REG_LIGHT_THRESHOLD)
            cur_threshold = data;
    endtask

    // One random event, weighted toward ticks so that ramps run to their ends.
    task automatic send_random_event(input int tick_pct);
        int         pick;
        logic [7:0] sample;

        pick = $urandom_range(99);
        if (pick < tick_pct)
        begin
            send_event(FUNC_TICK, 8'($urandom_range(255)));
        end
        else
        begin
            pick = $urandom_range(9);
            if (pick < 4)
            begin
                // Light samples, a third of them right at the threshold edge.
                sample = 8'($urandom_range(255));
                if ($urandom_range(2) == 0)
                    sample = cur_threshold + 8'($urandom_range(1));
                send_event(FUNC_LIGHT, sample);
            end
            else if (pick < 8)
            begin
                if ($urandom_range(1) == 0)
                    send_event(FUNC_CMD, CMD_OPEN);
                else
                    send_event(FUNC_CMD, 8'($urandom_range(255)));
            end
            else
            begin
                send_event(FUNC_SPARE, 8'($urandom_range(255)));
            end
        end
    endtask

    // Stimulus: directed events, then random phases under several settings.
    initial
    begin
        logic [7:0] bright_sample;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: idle tick, spare kind, threshold edge, command outside a ramp.
        send_event(FUNC_TICK, 8'hAA);
        send_event(FUNC_SPARE, 8'hFF);
        send_event(FUNC_LIGHT, 8'd15);
        send_event(FUNC_LIGHT, 8'd16);
        send_event(FUNC_CMD, 8'h00);
        send_event(FUNC_LIGHT, 8'd0);
        drain_results();

        // Short ramp: open request while dark, then light, full open and close.
        write_reg(REG_TICKS_PER_STEP, 8'd1);
        write_reg(REG_OPEN_DUTY, 8'd17);
        send_event(FUNC_CMD, CMD_OPEN);
        send_event(FUNC_LIGHT, 8'd255);
        repeat (4) send_event(FUNC_TICK, 8'h55);
        send_event(FUNC_CMD, 8'hFE);
        send_event(FUNC_LIGHT, 8'd0);
        repeat (4) send_event(FUNC_TICK, 8'h00);
        send_event(FUNC_SPARE, 8'h00);

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            drain_results();
            if (p < 2)
            begin
                send_idle_pct = 35;
                recv_idle_pct = 59;
            end
            else if (p < 4)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 35;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_LIGHT_THRESHOLD, thr_tab[p]);
            write_reg(REG_CLOSED_DUTY, closed_tab[p]);
            write_reg(REG_OPEN_DUTY, open_tab[p]);
            write_reg(REG_TICKS_PER_STEP, tps_tab[p]);

            // Open the panel first where the threshold allows it.
            bright_sample = (thr_tab[p] == 8'd255) ? 8'd255 : thr_tab[p] + 8'd1;
            send_event(FUNC_LIGHT, bright_sample);
            send_event(FUNC_CMD, CMD_OPEN);
            for (int n = 0; n < items_tab[p]; n++)
                send_random_event(tick_tab[p]);
        end

        drain_results();
        repeat (4) @(negedge clk);

        $display("Ran %0d events through six register settings and three idle patterns.",
                 events_sent);
        $display("Checked %0d results, with %0d duty steps and %0d finished ramps.",
                 results_checked, duty_steps, ramps_done);
        if (mismatches == 0 && awaited == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
